[hw/rtl/pcep_pkg.sv]
// ----------------------------------------------------------------------------
// pcep_pkg
// Shared types and constants of the palette color-effect and pack unit.
// ----------------------------------------------------------------------------
package pcep_pkg;

  localparam int ChW    = 8;   // color channel
  localparam int MultW  = 24;  // tint / add multiplier
  localparam int LightW = 10;  // one light factor
  localparam int ShW    = 6;   // tint / add shift
  localparam int DropW  = 3;
  localparam int PosW   = 5;
  localparam int WordW  = 32;
  localparam int IdxW   = 3;
  localparam int CfgW   = 42;
  localparam int NumCh  = 3;   // 0 red, 1 green, 2 blue

  localparam int ProdW  = MultW + ChW;    // 32
  localparam int LProdW = LightW + ChW;   // 18

  localparam logic [ChW-1:0] GreyRedOffs = 8'd21;

  // register indexes
  typedef enum logic [IdxW-1:0] {
    REG_TINT_RED   = 3'd0,
    REG_TINT_GREEN = 3'd1,
    REG_TINT_BLUE  = 3'd2,
    REG_ADD_RED    = 3'd3,
    REG_ADD_GREEN  = 3'd4,
    REG_ADD_BLUE   = 3'd5,
    REG_LIGHT      = 3'd6,
    REG_FORMAT     = 3'd7
  } pcep_reg_t;

  localparam logic [MultW-1:0]      MultRst  = 24'd1;
  localparam logic [3*LightW-1:0]   LightRst = 30'h0820820;
  localparam logic [CfgW-1:0]       FmtRst   = '0;

  // format_control field positions
  localparam int FcTintEn  = 0;
  localparam int FcAddEn   = 1;
  localparam int FcLightEn = 2;
  localparam int FcGreyAvg = 3;
  localparam int FcGreyGrn = 4;
  localparam int FcMode16  = 5;
  localparam int FcTintSh  = 6;
  localparam int FcAddSh   = 12;
  localparam int FcDrop    = 18;
  localparam int FcPos     = 27;

  // decoded configuration, handed from the register file to the datapath
  typedef struct packed {
    logic [NumCh-1:0][MultW-1:0]  tint;
    logic [NumCh-1:0][MultW-1:0]  add;
    logic [NumCh-1:0][LightW-1:0] light;
    logic                         tint_en;
    logic                         add_en;
    logic                         light_en;
    logic                         grey_avg;
    logic                         grey_green;
    logic                         mode16;
    logic [ShW-1:0]               tint_sh;
    logic [ShW-1:0]               add_sh;
    logic [NumCh-1:0][DropW-1:0]  drop;
    logic [NumCh-1:0][PosW-1:0]   pos;
  } pcep_cfg_t;

  typedef logic [NumCh-1:0][ChW-1:0] pcep_rgb_t;

endpackage

[hw/rtl/pcep_if.sv]
// ----------------------------------------------------------------------------
// pcep_if
// Valid/ready channels of the palette color-effect and pack unit.
// ----------------------------------------------------------------------------
interface pcep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       reserved;

  modport source (output valid, red, green, blue, reserved, input ready);
  modport sink   (input valid, red, green, blue, reserved, output ready);
endinterface

interface pcep_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_color;

  modport source (output valid, packed_color, input ready);
  modport sink   (input valid, packed_color, output ready);
endinterface

interface pcep_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [41:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/pcep_regs.sv]
// ----------------------------------------------------------------------------
// pcep_regs
// Configuration register file; decodes format_control into fields.
// ----------------------------------------------------------------------------
module pcep_regs (
  input  logic                clk,
  input  logic                rst_n,
  pcep_cfg_if.sink            cfg_ch,
  output pcep_pkg::pcep_cfg_t cfg_o
);
  import pcep_pkg::*;

  logic [NumCh-1:0][MultW-1:0] tint_r;
  logic [NumCh-1:0][MultW-1:0] add_r;
  logic [3*LightW-1:0]         light_r;
  logic [CfgW-1:0]             fmt_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_r  <= {NumCh{MultRst}};
      add_r   <= {NumCh{MultRst}};
      light_r <= LightRst;
      fmt_r   <= FmtRst;
    end else if (cfg_ch.valid) begin
      unique case (pcep_reg_t'(cfg_ch.index))
        REG_TINT_RED:   tint_r[0] <= cfg_ch.data[MultW-1:0];
        REG_TINT_GREEN: tint_r[1] <= cfg_ch.data[MultW-1:0];
        REG_TINT_BLUE:  tint_r[2] <= cfg_ch.data[MultW-1:0];
        REG_ADD_RED:    add_r[0]  <= cfg_ch.data[MultW-1:0];
        REG_ADD_GREEN:  add_r[1]  <= cfg_ch.data[MultW-1:0];
        REG_ADD_BLUE:   add_r[2]  <= cfg_ch.data[MultW-1:0];
        REG_LIGHT:      light_r   <= cfg_ch.data[3*LightW-1:0];
        REG_FORMAT:     fmt_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o            = '0;
    cfg_o.tint       = tint_r;
    cfg_o.add        = add_r;
    cfg_o.light      = light_r;
    cfg_o.tint_en    = fmt_r[FcTintEn];
    cfg_o.add_en     = fmt_r[FcAddEn];
    cfg_o.light_en   = fmt_r[FcLightEn];
    cfg_o.grey_avg   = fmt_r[FcGreyAvg];
    cfg_o.grey_green = fmt_r[FcGreyGrn];
    cfg_o.mode16     = fmt_r[FcMode16];
    cfg_o.tint_sh    = fmt_r[FcTintSh +: ShW];
    cfg_o.add_sh     = fmt_r[FcAddSh +: ShW];
    cfg_o.drop       = fmt_r[FcDrop +: NumCh*DropW];
    cfg_o.pos        = fmt_r[FcPos +: NumCh*PosW];
  end

endmodule

[hw/rtl/pcep_scale.sv]
// ----------------------------------------------------------------------------
// pcep_scale
// One channel of a multiply-and-shift stage, optionally on the complement.
// Two register stages: product, then shift / select.
// ----------------------------------------------------------------------------
module pcep_scale (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      act_i,   // stage on for this word
  input  logic                      inv_i,   // complement before and after
  input  logic [pcep_pkg::ChW-1:0]  ch_i,
  input  logic [pcep_pkg::MultW-1:0] mult_i,
  input  logic [pcep_pkg::ShW-1:0]  shift_i,
  output logic [pcep_pkg::ChW-1:0]  ch_o
);
  import pcep_pkg::*;

  logic [ChW-1:0]   opnd;
  logic [ProdW-1:0] prod_nxt, prod_r;
  logic             act_r;
  logic [ChW-1:0]   byp_r;
  logic [ProdW-1:0] shifted;
  logic [ChW-1:0]   res, ch_nxt, ch_r;

  assign opnd     = inv_i ? ~ch_i : ch_i;
  assign prod_nxt = ProdW'(mult_i) * ProdW'(opnd);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      act_r  <= act_i;
      byp_r  <= ch_i;
    end
  end

  // shifts of 32 and up clear the whole product
  assign shifted = shift_i[ShW-1] ? '0 : (prod_r >> shift_i[ShW-2:0]);
  assign res     = inv_i ? ~shifted[ChW-1:0] : shifted[ChW-1:0];
  assign ch_nxt  = act_r ? res : byp_r;

  always_ff @(posedge clk) begin
    if (en) ch_r <= ch_nxt;
  end

  assign ch_o = ch_r;

endmodule

[hw/rtl/pcep_light.sv]
// ----------------------------------------------------------------------------
// pcep_light
// Light stage: when active, channel times factor, divided by eight, saturated to 255.
// ----------------------------------------------------------------------------
module pcep_light (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 act_i,
  input  pcep_pkg::pcep_rgb_t  rgb_i,
  input  pcep_pkg::pcep_cfg_t  cfg_i,
  output pcep_pkg::pcep_rgb_t  rgb_o
);
  import pcep_pkg::*;

  pcep_rgb_t rgb_nxt, rgb_r;

  always_comb begin
    logic [LProdW-1:0] prod;
    logic [LProdW-4:0] quot;
    rgb_nxt = rgb_i;
    for (int c = 0; c < NumCh; c++) begin
      prod = LProdW'(cfg_i.light[c]) * LProdW'(rgb_i[c]);
      quot = prod[LProdW-1:3];
      if (act_i) rgb_nxt[c] = (quot > (LProdW-3)'(8'hFF)) ? 8'hFF : quot[ChW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) rgb_r <= rgb_nxt;
  end

  assign rgb_o = rgb_r;

endmodule

[hw/rtl/pcep_pack.sv]
// ----------------------------------------------------------------------------
// pcep_pack
// Packs the channels into a display word and swaps out full pure green in non-reserved words.
// ----------------------------------------------------------------------------
module pcep_pack (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          rsv_i,
  input  pcep_pkg::pcep_rgb_t           rgb_i,
  input  pcep_pkg::pcep_cfg_t           cfg_i,
  output logic [pcep_pkg::WordW-1:0]    word_o
);
  import pcep_pkg::*;

  logic [WordW-1:0] word_nxt, word_r;

  always_comb begin
    logic [DropW-1:0] drop;
    logic [ChW-1:0]   gmax;
    logic [WordW-1:0] word, wmask, top, below;
    word = '0;
    for (int c = 0; c < NumCh; c++) begin
      drop = cfg_i.mode16 ? cfg_i.drop[c] : '0;
      word = word | (WordW'(rgb_i[c] >> drop) << cfg_i.pos[c]);
    end
    wmask = cfg_i.mode16 ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    word  = word & wmask;
    gmax  = 8'hFF >> (cfg_i.mode16 ? cfg_i.drop[1] : '0);
    top   = WordW'(gmax) << cfg_i.pos[1];
    below = WordW'(gmax - 8'd1) << cfg_i.pos[1];
    word_nxt = (!rsv_i && word == top) ? (below & wmask) : word;
  end

  always_ff @(posedge clk) begin
    if (en) word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

[hw/rtl/palette_color_effect_pack_core.sv]
// ----------------------------------------------------------------------------
// palette_color_effect_pack_core
// Palette color-effect unit: grey, tint, inverse add, light, pack.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch takes one palette word (red, green, blue, reserved) per cycle when not stalled.
//  - out_ch gives one packed display word per input word, in order.
//  - cfg_ch writes the eight registers (index 0..7); it is always ready.
//    Write only while no word is in flight.
// Throughput: one word per clock when not stalled, fixed by a seven-stage pipeline:
//   grey, tint product, tint shift, add product, add shift, light, pack.
// Stall: the whole pipeline freezes while the output word is held
//   (out valid and not ready); in_ch.ready drops in that case only.
//   Bubbles in the pipeline are not squeezed out.
// Reset (rst_n low, synchronous): pipeline emptied, multipliers back to 1,
//   light factors to red 32, green 130, blue 8, format control to 0 (all effects off).
// ----------------------------------------------------------------------------
module palette_color_effect_pack_core (
  input  logic        clk,
  input  logic        rst_n,
  pcep_in_if.sink     in_ch,
  pcep_out_if.source  out_ch,
  pcep_cfg_if.sink    cfg_ch
);
  import pcep_pkg::*;

  localparam int NStg = 7;

  pcep_cfg_t        cfg;
  logic             en;
  logic [NStg:1]    v_r;     // valid per stage
  logic [NStg:1]    rsv_r;   // reserved mark per stage
  pcep_rgb_t        grey_nxt, grey_r;
  pcep_rgb_t        tint_rgb, add_rgb, light_rgb;
  logic [WordW-1:0] word;

  pcep_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  // pipeline moves unless the finished word is held by the receiver
  assign en          = !v_r[NStg] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NStg-1:1], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) rsv_r <= {rsv_r[NStg-1:1], in_ch.reserved};
  end

  // stage 1: grey modes; average first, grey-green on its result
  always_comb begin
    logic [ChW+1:0] sum;
    logic [ChW-1:0] r, g, b;
    sum = '0;
    r = in_ch.red;
    g = in_ch.green;
    b = in_ch.blue;
    if (!in_ch.reserved && cfg.grey_avg) begin
      sum = (ChW+2)'(r) + (ChW+2)'(g) + (ChW+2)'(b);
      r   = sum[ChW+1:2];
      g   = r;
    end
    if (!in_ch.reserved && cfg.grey_green) begin
      sum = (ChW+2)'(r) + (ChW+2)'(g) + (ChW+2)'(b);
      g   = sum[ChW+1:2];
      b   = g;
      r   = g + GreyRedOffs;  // wraps to 8 bits
    end
    grey_nxt = {b, g, r};
  end

  always_ff @(posedge clk) begin
    if (en) grey_r <= grey_nxt;
  end

  // stages 2-3 tint, stages 4-5 inverse add
  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    pcep_scale u_tint (
      .clk     (clk),
      .en      (en),
      .act_i   (cfg.tint_en && !rsv_r[1]),
      .inv_i   (1'b0),
      .ch_i    (grey_r[c]),
      .mult_i  (cfg.tint[c]),
      .shift_i (cfg.tint_sh),
      .ch_o    (tint_rgb[c])
    );

    pcep_scale u_add (
      .clk     (clk),
      .en      (en),
      .act_i   (cfg.add_en && !rsv_r[3]),
      .inv_i   (1'b1),
      .ch_i    (tint_rgb[c]),
      .mult_i  (cfg.add[c]),
      .shift_i (cfg.add_sh),
      .ch_o    (add_rgb[c])
    );
  end

  // stage 6 light
  pcep_light u_light (
    .clk   (clk),
    .en    (en),
    .act_i (cfg.light_en && !rsv_r[5]),
    .rgb_i (add_rgb),
    .cfg_i (cfg),
    .rgb_o (light_rgb)
  );

  // stage 7 pack, also the output register
  pcep_pack u_pack (
    .clk    (clk),
    .en     (en),
    .rsv_i  (rsv_r[6]),
    .rgb_i  (light_rgb),
    .cfg_i  (cfg),
    .word_o (word)
  );

  assign out_ch.valid        = v_r[NStg];
  assign out_ch.packed_color = word;

  // ---------------------------------------------------------------- checks
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NStg] && !out_ch.ready) |=> ($stable(v_r) && $stable(light_rgb)))
    else $error("pipeline moved while output stalled");

  a_mode16_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && cfg.mode16) |-> (out_ch.packed_color[WordW-1:16] == '0))
    else $error("upper half set in 16-bit mode");

endmodule

[sim/pcep_check.sv]
// ----------------------------------------------------------------------------
// pcep_check
// Watches the three channels of the palette color-effect unit. Keeps its own
// copy of the registers, predicts each packed word and compares in order.
// ----------------------------------------------------------------------------
module pcep_check (
  input  logic clk,
  input  logic rst_n,
  pcep_in_if   in_ch,
  pcep_out_if  out_ch,
  pcep_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_words,
  output int   checked_words,
  output int   green_swaps
);
  import pcep_pkg::*;

  typedef struct {
    logic [ChW-1:0]   r;
    logic [ChW-1:0]   g;
    logic [ChW-1:0]   b;
    logic             res;
    logic [WordW-1:0] word;
  } exp_word_t;

  exp_word_t exp_q [$];

  logic [MultW-1:0]    tint_m [NumCh];
  logic [MultW-1:0]    add_m  [NumCh];
  logic [3*LightW-1:0] light_f;
  logic [CfgW-1:0]     fmt;

  int n_fail    = 0;
  int n_pending = 0;
  int n_checked = 0;
  int n_swaps   = 0;

  assign fail_count    = n_fail;
  assign pending_words = n_pending;
  assign checked_words = n_checked;
  assign green_swaps   = n_swaps;

  task automatic report(input string msg);
    $display("ERROR: %0t: %s", $time, msg);
    n_fail++;
  endtask

  // effect chain, then pack, then the pure-green swap
  function automatic logic [WordW-1:0] predict_word(input logic [ChW-1:0] r_in,
                                                    input logic [ChW-1:0] g_in,
                                                    input logic [ChW-1:0] b_in,
                                                    input logic res,
                                                    output logic swapped);
    logic [63:0]      c [NumCh];
    logic [63:0]      v;
    logic [63:0]      word;
    logic [63:0]      top;
    logic [63:0]      below;
    logic [63:0]      wmask;
    logic [DropW-1:0] drop [NumCh];
    logic [PosW-1:0]  pos [NumCh];
    logic             m16;
    int               sh;
    c[0] = 64'(r_in);
    c[1] = 64'(g_in);
    c[2] = 64'(b_in);
    m16 = fmt[FcMode16];
    for (int i = 0; i < NumCh; i++) begin
      drop[i] = m16 ? fmt[FcDrop + DropW*i +: DropW] : '0;
      pos[i]  = fmt[FcPos + PosW*i +: PosW];
    end
    wmask = m16 ? 64'hFFFF : 64'hFFFF_FFFF;
    swapped = 1'b0;
    if (!res) begin
      if (fmt[FcGreyAvg]) begin
        c[0] = ((c[0] + c[1] + c[2]) >> 2) & 64'hFF;
        c[1] = c[0];
      end
      if (fmt[FcGreyGrn]) begin
        c[1] = ((c[0] + c[1] + c[2]) >> 2) & 64'hFF;
        c[2] = c[1];
        c[0] = (c[1] + 64'(GreyRedOffs)) & 64'hFF;
      end
      if (fmt[FcTintEn]) begin
        sh = int'(fmt[FcTintSh +: ShW]);
        for (int i = 0; i < NumCh; i++)
          c[i] = ((64'(tint_m[i]) * c[i]) >> sh) & 64'hFF;
      end
      if (fmt[FcAddEn]) begin
        sh = int'(fmt[FcAddSh +: ShW]);
        for (int i = 0; i < NumCh; i++) begin
          v = ~c[i] & 64'hFF;
          v = ((64'(add_m[i]) * v) >> sh) & 64'hFF;
          c[i] = ~v & 64'hFF;
        end
      end
      if (fmt[FcLightEn]) begin
        for (int i = 0; i < NumCh; i++) begin
          v = 64'(light_f[LightW*i +: LightW]) * c[i] / 8;
          c[i] = (v > 64'd255) ? 64'd255 : v;
        end
      end
    end
    word = '0;
    for (int i = 0; i < NumCh; i++)
      word = word | ((c[i] >> drop[i]) << pos[i]);
    word = word & wmask;
    if (!res) begin
      top   = ((64'hFF >> drop[1]) << pos[1]) & 64'hFFFF_FFFF;
      below = (((64'hFF >> drop[1]) - 64'd1) << pos[1]) & 64'hFFFF_FFFF;
      if (word == top) begin
        word = below & wmask;
        swapped = 1'b1;
      end
    end
    return word[WordW-1:0];
  endfunction

  always @(posedge clk) begin : watch
    exp_word_t e;
    logic      swapped;
    if (!rst_n) begin
      for (int i = 0; i < NumCh; i++) begin
        tint_m[i] = MultRst;
        add_m[i]  = MultRst;
      end
      light_f = LightRst;
      fmt     = FmtRst;
      exp_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (pcep_reg_t'(cfg_ch.index))
          REG_TINT_RED:   tint_m[0] = cfg_ch.data[MultW-1:0];
          REG_TINT_GREEN: tint_m[1] = cfg_ch.data[MultW-1:0];
          REG_TINT_BLUE:  tint_m[2] = cfg_ch.data[MultW-1:0];
          REG_ADD_RED:    add_m[0]  = cfg_ch.data[MultW-1:0];
          REG_ADD_GREEN:  add_m[1]  = cfg_ch.data[MultW-1:0];
          REG_ADD_BLUE:   add_m[2]  = cfg_ch.data[MultW-1:0];
          REG_LIGHT:      light_f   = cfg_ch.data[3*LightW-1:0];
          REG_FORMAT:     fmt       = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        e.r   = in_ch.red;
        e.g   = in_ch.green;
        e.b   = in_ch.blue;
        e.res = in_ch.reserved;
        e.word = predict_word(e.r, e.g, e.b, e.res, swapped);
        if (swapped)
          n_swaps++;
        exp_q.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          report($sformatf("packed_color %08h with no word outstanding",
                           out_ch.packed_color));
        end else begin
          e = exp_q.pop_front();
          n_checked++;
          if (out_ch.packed_color !== e.word)
            report($sformatf("r=%02h g=%02h b=%02h res=%0b: packed_color %08h, want %08h",
                             e.r, e.g, e.b, e.res, out_ch.packed_color, e.word));
        end
      end
    end
    n_pending = exp_q.size();
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Top of the palette color-effect unit bench. Drives palette words and
// register writes, runs directed corners then random register settings under
// several idle and stall mixes, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
  import pcep_pkg::*;

  localparam int CycleLimit      = 200000;
  localparam int HoldCycles      = 300;     // long receiver hold-off
  localparam int TailCycles      = 16;      // longer than the pipeline depth
  localparam int RandSettings    = 3;       // random settings per idle mix
  localparam int WordsPerSetting = 90;
  localparam int PressureWords   = 48;

  // effect enables, laid out as format_control bits 4..0
  localparam logic [4:0] FxNone    = 5'd0;
  localparam logic [4:0] FxTint    = 5'(1 << FcTintEn);
  localparam logic [4:0] FxAdd     = 5'(1 << FcAddEn);
  localparam logic [4:0] FxLight   = 5'(1 << FcLightEn);
  localparam logic [4:0] FxGreyAvg = 5'(1 << FcGreyAvg);
  localparam logic [4:0] FxGreyGrn = 5'(1 << FcGreyGrn);

  localparam logic [MultW-1:0]  MultMax  = '1;
  localparam logic [LightW-1:0] LightMax = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // idle mix: sender gap and receiver stall chance, in percent
  int idle_tab  [4] = '{0, 47, 0, 11};
  int stall_tab [4] = '{0, 0, 47, 11};
  int idle_pct  = 0;   // read only by the stimulus process
  int stall_pct = 0;   // changed with NBAs, read by the receiver

  // hold-off request: the receiver starts a hold when the sequence moves
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycle_cnt  = 0;
  int n_sent     = 0;
  int n_reserved = 0;
  int n_settings = 0;

  int chk_fails;
  int chk_pending;
  int chk_checked;
  int chk_swaps;

  pcep_in_if  in_ch ();
  pcep_out_if out_ch ();
  pcep_cfg_if cfg_ch ();

  palette_color_effect_pack_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pcep_check chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (chk_fails),
    .pending_words (chk_pending),
    .checked_words (chk_checked),
    .green_swaps   (chk_swaps)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [CfgW-1:0] make_fmt(input logic [4:0]       fx,
                                               input logic             m16,
                                               input logic [ShW-1:0]   tsh,
                                               input logic [ShW-1:0]   ash,
                                               input logic [DropW-1:0] dr,
                                               input logic [DropW-1:0] dg,
                                               input logic [DropW-1:0] db,
                                               input logic [PosW-1:0]  pr,
                                               input logic [PosW-1:0]  pg,
                                               input logic [PosW-1:0]  pb);
    logic [CfgW-1:0] f;
    f = '0;
    f[FcGreyGrn:FcTintEn]    = fx;
    f[FcMode16]              = m16;
    f[FcTintSh +: ShW]       = tsh;
    f[FcAddSh +: ShW]        = ash;
    f[FcDrop +: 3*DropW]     = {db, dg, dr};
    f[FcPos +: 3*PosW]       = {pb, pg, pr};
    return f;
  endfunction

  // multipliers lean on 0, 1, all ones and small values
  function automatic logic [MultW-1:0] pick_mult();
    case ($urandom_range(7))
      0:       return '0;
      1:       return MultRst;
      2:       return MultMax;
      3, 4:    return MultW'($urandom_range(255));
      default: return MultW'($urandom);
    endcase
  endfunction

  // shifts: mostly modest, sometimes 32 and up (product shifted away)
  function automatic logic [ShW-1:0] pick_shift();
    case ($urandom_range(7))
      0:       return ShW'($urandom_range(63, 32));
      1:       return '0;
      default: return ShW'($urandom_range(16));
    endcase
  endfunction

  function automatic logic [LightW-1:0] pick_light();
    case ($urandom_range(3))
      0:       return LightW'(8);
      1:       return LightMax;
      default: return LightW'($urandom_range(1023));
    endcase
  endfunction

  // Stop offering words and wait until every expected word is back.
  // The checker updates at posedge, so it is read at negedge.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
  endtask

  // Write all eight registers, back to back, with the pipeline empty.
  task automatic load_regs(input logic [MultW-1:0]    t_r,
                           input logic [MultW-1:0]    t_g,
                           input logic [MultW-1:0]    t_b,
                           input logic [MultW-1:0]    a_r,
                           input logic [MultW-1:0]    a_g,
                           input logic [MultW-1:0]    a_b,
                           input logic [3*LightW-1:0] lf,
                           input logic [CfgW-1:0]     f);
    logic [CfgW-1:0] reg_val [8];
    pcep_reg_t       idx;
    reg_val[REG_TINT_RED]   = CfgW'(t_r);
    reg_val[REG_TINT_GREEN] = CfgW'(t_g);
    reg_val[REG_TINT_BLUE]  = CfgW'(t_b);
    reg_val[REG_ADD_RED]    = CfgW'(a_r);
    reg_val[REG_ADD_GREEN]  = CfgW'(a_g);
    reg_val[REG_ADD_BLUE]   = CfgW'(a_b);
    reg_val[REG_LIGHT]      = CfgW'(lf);
    reg_val[REG_FORMAT]     = f;
    drain();
    idx = idx.first();
    do begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= reg_val[idx];
      do @(posedge clk); while (!cfg_ch.ready);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Offer one word; valid stays high after acceptance so that the next
  // word can follow with no bubble.
  task automatic send_word(input logic [7:0] r,
                           input logic [7:0] g,
                           input logic [7:0] b,
                           input logic       res);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red      <= r;
    in_ch.green    <= g;
    in_ch.blue     <= b;
    in_ch.reserved <= res;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    if (res)
      n_reserved++;
  endtask

  // Random word; now and then a corner (black, white, pure green).
  task automatic send_random_word();
    logic res;
    res = ($urandom_range(7) == 0);
    case ($urandom_range(15))
      0:       send_word(8'h00, 8'hFF, 8'h00, res);
      1:       send_word(8'hFF, 8'hFF, 8'hFF, res);
      2:       send_word(8'h00, 8'h00, 8'h00, res);
      default: send_word(8'($urandom), 8'($urandom), 8'($urandom), res);
    endcase
  endtask

  // Random register setting: common 32-bit and 565 layouts, or anything.
  task automatic load_random_setting();
    logic [DropW-1:0] d [NumCh];
    logic [PosW-1:0]  p [NumCh];
    logic [4:0]       fx;
    logic             m16;
    for (int i = 0; i < NumCh; i++) begin
      d[i] = DropW'($urandom);
      p[i] = PosW'($urandom);
    end
    m16 = $urandom_range(1);
    case ($urandom_range(3))
      0: begin
        m16 = 1'b0;
        p = '{5'd16, 5'd8, 5'd0};
      end
      1: begin
        m16 = 1'b1;
        d = '{3'd3, 3'd2, 3'd3};
        p = '{5'd11, 5'd5, 5'd0};
      end
      default: ;
    endcase
    fx = ($urandom_range(4) == 0) ? FxNone : 5'($urandom_range(31));
    load_regs(pick_mult(), pick_mult(), pick_mult(),
              pick_mult(), pick_mult(), pick_mult(),
              {pick_light(), pick_light(), pick_light()},
              make_fmt(fx, m16, pick_shift(), pick_shift(),
                       d[0], d[1], d[2], p[0], p[1], p[2]));
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.red      = '0;
    in_ch.green    = '0;
    in_ch.blue     = '0;
    in_ch.reserved = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_TINT_RED;
    cfg_ch.data    = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed corners ---

    // reset registers: no effects, all channels at bit 0; a white word
    // hits the pure-green pattern (0xFF at position 0) and is swapped
    send_word(8'h00, 8'h00, 8'h00, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_word(8'h55, 8'hAA, 8'h0F, 1'b0);

    // 32-bit 8:8:8 layout, no effects: pure green swapped, reserved kept
    load_regs(MultRst, MultRst, MultRst, MultRst, MultRst, MultRst, LightRst,
              make_fmt(FxNone, 1'b0, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0,
                       5'd16, 5'd8, 5'd0));
    send_word(8'h00, 8'hFF, 8'h00, 1'b0);
    send_word(8'h00, 8'hFF, 8'h00, 1'b1);
    send_word(8'hFF, 8'h00, 8'hFF, 1'b0);

    // 16-bit 565: low bits dropped, green swap on the 6-bit maximum
    load_regs(MultRst, MultRst, MultRst, MultRst, MultRst, MultRst, LightRst,
              make_fmt(FxNone, 1'b1, 6'd0, 6'd0, 3'd3, 3'd2, 3'd3,
                       5'd11, 5'd5, 5'd0));
    send_word(8'h07, 8'hFF, 8'h07, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // grey-average, tint, inverse add and light together; red light
    // saturates, green light is zero
    load_regs(24'd3, MultMax, 24'd0, 24'd2, MultMax, 24'd0,
              {10'd8, 10'd0, LightMax},
              make_fmt(FxGreyAvg | FxTint | FxAdd | FxLight, 1'b0, 6'd1, 6'd2,
                       3'd0, 3'd0, 3'd0, 5'd16, 5'd8, 5'd0));
    send_word(8'd200, 8'd100, 8'd50, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h00, 8'h00, 8'h00, 1'b0);
    send_word(8'hFF, 8'h00, 8'h00, 1'b1);

    // grey-green (red offset may wrap) with light, unusual positions
    load_regs(MultRst, MultRst, MultRst, MultRst, MultRst, MultRst,
              {LightMax, 10'd12, 10'd16},
              make_fmt(FxGreyGrn | FxLight, 1'b0, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0,
                       5'd0, 5'd10, 5'd20));
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'd10, 8'd20, 8'd30, 1'b0);
    send_word(8'h00, 8'h00, 8'h00, 1'b0);

    // shifts past the product width, all channels at bit 31: the top bit
    // equals the green pattern and is swapped away
    load_regs(MultMax, MultMax, MultMax, MultMax, MultMax, MultMax, LightRst,
              make_fmt(FxTint | FxAdd, 1'b0, 6'd40, 6'd63, 3'd0, 3'd0, 3'd0,
                       5'd31, 5'd31, 5'd31));
    send_word(8'd123, 8'd45, 8'd67, 1'b0);
    send_word(8'd1, 8'd2, 8'd3, 1'b1);

    // 16-bit with maximum drops at bit 15, tint shift of exactly 32
    load_regs(24'd7, 24'd7, 24'd7, MultRst, MultRst, MultRst, LightRst,
              make_fmt(FxTint, 1'b1, 6'd32, 6'd0, 3'd7, 3'd7, 3'd7,
                       5'd15, 5'd15, 5'd15));
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // --- random settings under each idle mix ---
    for (int mix = 0; mix < 4; mix++) begin
      idle_pct  = idle_tab[mix];
      stall_pct <= stall_tab[mix];
      for (int s = 0; s < RandSettings; s++) begin
        load_random_setting();
        repeat (WordsPerSetting) send_random_word();
      end
      if (mix == 0) begin
        // Back pressure: the receiver holds off while words keep coming,
        // so the pipeline fills and input ready drops; then the sender
        // waits for every word to come back.
        load_random_setting();
        hold_seq <= hold_seq + 1;
        repeat (PressureWords) send_random_word();
        drain();
      end
    end

    idle_pct  = 0;
    stall_pct <= 0;
    drain();
    repeat (TailCycles) @(posedge clk);
    @(negedge clk);

    $display("Summary: %0d palette words sent (%0d reserved) under %0d register settings",
             n_sent, n_reserved, n_settings);
    $display("Summary: %0d packed words checked, %0d green swaps, %0d mismatches",
             chk_checked, chk_swaps, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
